// ===== src/grw_pkg.sv =====
// Shared types, constants and helper functions of the grid ray caster.
package grw_pkg;

  localparam int FRACTION_BITS = 8;
  localparam int TILE_SHIFT    = 14;   // one tile is 64 pixels of 256 raw units
  localparam int MAP_SIDE      = 64;
  localparam int IDX_W         = 6;
  localparam int ADDR_W        = 2 * IDX_W;
  localparam int PLAYER_W      = 20;
  localparam int ANGLE_W       = 12;
  localparam int TURN_W        = 32;
  localparam int MAPREG_W      = 7;
  localparam int CFG_IDX_W     = 8;
  localparam int HIT_W         = 21;
  localparam int DIST_W        = 22;
  localparam int COORD_W       = 36;
  localparam int TILE_IDX_W    = COORD_W - TILE_SHIFT;
  localparam int TRIG_W        = 34;
  localparam int RATIO_W       = 28;
  localparam int RATIO_BITS    = 27;
  localparam int CORDIC_STEPS  = 30;
  localparam int DELTA_W       = 17;
  localparam int PROD_W        = DELTA_W + RATIO_W;
  localparam int MAG_W         = 24;
  localparam int SQ_W          = 2 * MAG_W;
  localparam int ROOT_STEPS    = 24;

  localparam logic signed [TRIG_W-1:0]  CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [COORD_W-1:0] TILE_RAW    = 36'sd16384;
  localparam logic signed [COORD_W-1:0] PIXEL_RAW   = 36'sd256;
  localparam logic signed [RATIO_W-1:0] RATIO_CLAMP = 28'sd67108864;

  typedef logic [1:0] tile_t;
  localparam tile_t TILE_EMPTY = 2'd0;
  localparam tile_t TILE_WALL  = 2'd1;
  localparam tile_t TILE_DOOR  = 2'd2;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_CAST  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 8'd1;

  typedef enum logic [3:0] {
    ST_IDLE, ST_TRIG, ST_TAN, ST_COT, ST_MUL, ST_LOAD, ST_PROBE, ST_WALK,
    ST_SQ_X, ST_SQ_Y, ST_ROOT_GO, ST_ROOT, ST_EMIT
  } state_t;

  typedef struct packed {
    logic              stop;
    logic [ADDR_W-1:0] addr;
  } probe_t;

  // Arctangent of 2^-i as a fraction of a full turn scaled by 2^32.
  function automatic logic [29:0] atan_turn(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10680862;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  // Tile lookup for a probe point: stops on non-positive coordinates or outside the used map.
  function automatic probe_t probe_at(input logic signed [COORD_W-1:0] x,
                                      input logic signed [COORD_W-1:0] y,
                                      input logic [MAPREG_W-1:0] w,
                                      input logic [MAPREG_W-1:0] h);
    probe_t p;
    logic [TILE_IDX_W-1:0] xm;
    logic [TILE_IDX_W-1:0] ym;
    logic [MAPREG_W-1:0] we;
    logic [MAPREG_W-1:0] he;
    we = (w > MAPREG_W'(MAP_SIDE)) ? MAPREG_W'(MAP_SIDE) : w;
    he = (h > MAPREG_W'(MAP_SIDE)) ? MAPREG_W'(MAP_SIDE) : h;
    xm = x[COORD_W-1:TILE_SHIFT];
    ym = y[COORD_W-1:TILE_SHIFT];
    p.stop = (x <= 0) || (y <= 0) || (xm >= TILE_IDX_W'(we)) || (ym >= TILE_IDX_W'(he));
    p.addr = {ym[IDX_W-1:0], xm[IDX_W-1:0]};
    return p;
  endfunction

  function automatic logic signed [HIT_W-1:0] sat_hit(input logic signed [COORD_W-1:0] v);
    logic signed [HIT_W-1:0] r;
    if (v > 36'sd1048575) begin
      r = 21'sd1048575;
    end else if (v < -36'sd1048576) begin
      r = -21'sd1048576;
    end else begin
      r = v[HIT_W-1:0];
    end
    return r;
  endfunction

  // Magnitude of a coordinate difference, capped at 2^23.
  function automatic logic [MAG_W-1:0] cap_mag(input logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] m;
    m = v[COORD_W-1] ? -v : v;
    return (m > 36'sd8388608) ? 24'd8388608 : m[MAG_W-1:0];
  endfunction

endpackage

// ===== src/grw_ifs.sv =====
// Handshake channel interfaces of the grid ray caster.
interface grw_in_if;
  import grw_pkg::*;
  logic                valid;
  logic                ready;
  logic                command;
  logic [IDX_W-1:0]    tile_col;
  logic [IDX_W-1:0]    tile_row;
  logic [1:0]          tile_code;
  logic [PLAYER_W-1:0] player_x;
  logic [PLAYER_W-1:0] player_y;
  logic [ANGLE_W-1:0]  angle;
  modport source(output valid, command, tile_col, tile_row, tile_code, player_x, player_y,
                 angle, input ready);
  modport sink(input valid, command, tile_col, tile_row, tile_code, player_x, player_y,
               angle, output ready);
endinterface

interface grw_out_if;
  import grw_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [HIT_W-1:0]  h_hit_x;
  logic signed [HIT_W-1:0]  h_hit_y;
  logic signed [HIT_W-1:0]  v_hit_x;
  logic signed [HIT_W-1:0]  v_hit_y;
  logic [DIST_W-1:0]        h_distance;
  logic [DIST_W-1:0]        v_distance;
  logic                     h_door;
  logic                     v_door;
  modport source(output valid, h_hit_x, h_hit_y, v_hit_x, v_hit_y, h_distance, v_distance,
                 h_door, v_door, input ready);
  modport sink(input valid, h_hit_x, h_hit_y, v_hit_x, v_hit_y, h_distance, v_distance,
               h_door, v_door, output ready);
endinterface

interface grw_cfg_if;
  import grw_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [MAPREG_W-1:0]  data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== src/grw_tile_mem.sv =====
// Tile map memory with a clearing sweep after reset.
module grw_tile_mem import grw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  tile_t             wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output tile_t             rd_data,
  output logic              busy
);
  tile_t mem [0:(1<<ADDR_W)-1];
  logic [ADDR_W:0] clr_cnt_r, clr_cnt_nxt;

  assign busy = ~clr_cnt_r[ADDR_W];

  always_comb begin
    clr_cnt_nxt = busy ? clr_cnt_r + 1'b1 : clr_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else begin
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_cnt_r[ADDR_W-1:0]] <= TILE_EMPTY;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

// ===== src/grw_cordic.sv =====
// Iterative CORDIC giving sine and cosine of the ray angle, one rotation a cycle.
module grw_cordic import grw_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [ANGLE_W-1:0]       angle,
  output logic                     done,
  output logic signed [TRIG_W-1:0] sin_q,
  output logic signed [TRIG_W-1:0] cos_q
);
  localparam logic signed [32:0] QUARTER = 33'sh040000000;
  localparam logic signed [32:0] HALF    = 33'sh080000000;

  logic signed [TRIG_W-1:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [32:0]       z_r, z_nxt;
  logic                     flip_r, flip_nxt;
  logic [4:0]               i_r, i_nxt;
  logic                     run_r, run_nxt, done_r, done_nxt;
  logic signed [32:0]       z_start;
  logic                     flip_start;
  logic signed [TRIG_W-1:0] xs, ys;
  logic signed [32:0]       at;

  always_comb begin
    z_start    = $signed({angle[ANGLE_W-1], angle, (TURN_W-ANGLE_W)'(0)});
    flip_start = 1'b0;
    if (z_start > QUARTER) begin
      z_start    = z_start - HALF;
      flip_start = 1'b1;
    end else if (z_start < -QUARTER) begin
      z_start    = z_start + HALF;
      flip_start = 1'b1;
    end
  end

  always_comb begin
    xs       = x_r >>> i_r;
    ys       = y_r >>> i_r;
    at       = $signed({3'b000, atan_turn(i_r)});
    x_nxt    = x_r;
    y_nxt    = y_r;
    z_nxt    = z_r;
    flip_nxt = flip_r;
    i_nxt    = i_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      x_nxt    = CORDIC_GAIN;
      y_nxt    = '0;
      z_nxt    = z_start;
      flip_nxt = flip_start;
      i_nxt    = '0;
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (!z_r[32]) begin
        x_nxt = x_r - ys;
        y_nxt = y_r + xs;
        z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + ys;
        y_nxt = y_r - xs;
        z_nxt = z_r + at;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == 5'(CORDIC_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    flip_r <= flip_nxt;
    i_r    <= i_nxt;
  end

  assign done  = done_r;
  assign sin_q = flip_r ? -y_r : y_r;
  assign cos_q = flip_r ? -x_r : x_r;
endmodule

// ===== src/grw_div.sv =====
// Restoring divider for the clamped Q16 tangent ratios, one quotient bit a cycle.
module grw_div import grw_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic signed [TRIG_W-1:0]  num,
  input  logic signed [TRIG_W-1:0]  den,
  output logic                      done,
  output logic signed [RATIO_W-1:0] quo
);
  localparam int N_W  = TRIG_W + 16;
  localparam int DD_W = TRIG_W + RATIO_BITS;

  logic [N_W-1:0]        rem_r, rem_nxt;
  logic [DD_W-1:0]       dd_r, dd_nxt;
  logic [RATIO_BITS-1:0] q_r, q_nxt;
  logic [4:0]            cnt_r, cnt_nxt;
  logic                  run_r, run_nxt, done_r, done_nxt;
  logic                  neg_r, neg_nxt, sat_r, sat_nxt;
  logic [TRIG_W-1:0]     num_mag, den_mag;
  logic [N_W-1:0]        n_start;
  logic [DD_W:0]         d_top;
  logic [RATIO_W-1:0]    q_mag;

  always_comb begin
    num_mag  = num[TRIG_W-1] ? TRIG_W'(-num) : TRIG_W'(num);
    den_mag  = den[TRIG_W-1] ? TRIG_W'(-den) : TRIG_W'(den);
    n_start  = {num_mag, 16'd0};
    d_top    = {den_mag, RATIO_BITS'(0)};
    rem_nxt  = rem_r;
    dd_nxt   = dd_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    sat_nxt  = sat_r;
    if (start) begin
      rem_nxt = n_start;
      dd_nxt  = {den_mag, (RATIO_BITS-1)'(0)};
      q_nxt   = '0;
      cnt_nxt = '0;
      if (den_mag == '0) begin
        // Zero divisor: clamp with the sign of the dividend.
        neg_nxt  = num[TRIG_W-1];
        sat_nxt  = 1'b1;
        done_nxt = 1'b1;
      end else begin
        neg_nxt = num[TRIG_W-1] ^ den[TRIG_W-1];
        sat_nxt = (DD_W+1)'(n_start) >= d_top;
        if ((DD_W+1)'(n_start) >= d_top) begin
          done_nxt = 1'b1;
        end else begin
          run_nxt = 1'b1;
        end
      end
    end else if (run_r) begin
      if (DD_W'(rem_r) >= dd_r) begin
        rem_nxt = rem_r - N_W'(dd_r);
        q_nxt   = {q_r[RATIO_BITS-2:0], 1'b1};
      end else begin
        q_nxt   = {q_r[RATIO_BITS-2:0], 1'b0};
      end
      dd_nxt  = dd_r >> 1;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 5'(RATIO_BITS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dd_r  <= dd_nxt;
    q_r   <= q_nxt;
    cnt_r <= cnt_nxt;
    neg_r <= neg_nxt;
    sat_r <= sat_nxt;
  end

  always_comb begin
    if (sat_r || (RATIO_W'(q_r) > RATIO_W'(RATIO_CLAMP))) begin
      q_mag = RATIO_W'(RATIO_CLAMP);
    end else begin
      q_mag = RATIO_W'(q_r);
    end
  end

  assign done = done_r;
  assign quo  = neg_r ? -$signed(q_mag) : $signed(q_mag);
endmodule

// ===== src/grw_sqrt.sv =====
// Bit-pair integer square root, one result bit a cycle.
module grw_sqrt import grw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SQ_W-1:0]   n,
  output logic              done,
  output logic [MAG_W-1:0]  root
);
  logic [SQ_W-1:0] n_r, n_nxt, res_r, res_nxt, bit_r, bit_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic            run_r, run_nxt, done_r, done_nxt;
  logic [SQ_W-1:0] trial;

  always_comb begin
    trial    = res_r + bit_r;
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt   = n;
      res_nxt = '0;
      bit_nxt = SQ_W'(1) << (SQ_W - 2);
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (n_r >= trial) begin
        n_nxt   = n_r - trial;
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == 5'(ROOT_STEPS - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done = done_r;
  assign root = res_r[MAG_W-1:0];
endmodule

// ===== src/grid_ray_wall_intersection.sv =====
// Top level of the grid ray caster: tile map, ray walker and sequencer.
//
// Use: items arrive on in_ch. An item with command write stores one 2-bit tile at
// (tile_row, tile_col) in the 64 x 64 tile map and gives no result; the sequencer stays idle.
// An item with command cast walks a ray from (player_x, player_y) at the given angle,
// first across horizontal grid lines, then across vertical ones, and gives one result
// on out_ch with both stop points, their distances and door flags.
// A cast runs 30 CORDIC rotations, two 27-bit divisions for tangent and cotangent, two
// walks of one tile read a cycle (up to 65 reads each, set by the single read port of
// the tile memory) and two 24-step square roots.
// Only one item is in flight; in_ch.ready is high while idle and the tile sweep is over.
// The finished result sits in an output register, so the next item is taken while a
// result still waits; a stalled receiver holds a following cast only at its very end.
// cfg_ch writes map_width (index 0) or map_height (index 1); it is always ready. It is to be
// written only while no cast is running; the block itself does not enforce this.
// After reset the tile memory is swept to empty, one tile a cycle, over all 4096 tiles;
// no item is accepted during the sweep; the map registers reset to 64.
module grid_ray_wall_intersection import grw_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  grw_in_if.sink     in_ch,
  grw_out_if.source  out_ch,
  grw_cfg_if.sink    cfg_ch
);
  state_t state_r, state_nxt;

  logic [PLAYER_W-1:0]       px_r, py_r;
  logic [ANGLE_W-1:0]        ang_r;
  logic                      down_r, left_r;
  logic signed [RATIO_W-1:0] tn_r, tn_nxt, ct_r, ct_nxt;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [COORD_W-1:0] wx_r, wx_nxt, wy_r, wy_nxt, wsx_r, wsx_nxt, wsy_r, wsy_nxt;
  logic [MAPREG_W-1:0]       k_r, k_nxt;
  logic                      stop_r, stop_nxt;
  logic                      phase_r, phase_nxt;
  logic signed [COORD_W-1:0] hx_r, hx_nxt, hy_r, hy_nxt, vx_r, vx_nxt, vy_r, vy_nxt;
  logic                      hd_r, hd_nxt, vd_r, vd_nxt;
  logic [SQ_W-1:0]           sqx_r, sqx_nxt, sqy_r, sqy_nxt;
  logic [DIST_W-1:0]         hdist_r, hdist_nxt;
  logic [MAPREG_W-1:0]       map_w_r, map_h_r;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [HIT_W-1:0]   o_hx_r, o_hy_r, o_vx_r, o_vy_r;
  logic [DIST_W-1:0]         o_hdist_r, o_vdist_r;
  logic                      o_hd_r, o_vd_r;
  logic                      out_load;

  logic                      accept, cast_go, mem_busy;
  logic                      cordic_start, cordic_done;
  logic signed [TRIG_W-1:0]  sin_q, cos_q;
  logic                      div_start, div_done;
  logic signed [TRIG_W-1:0]  div_num, div_den;
  logic signed [RATIO_W-1:0] div_quo;
  logic                      sqrt_start, sqrt_done;
  logic [MAG_W-1:0]          root;
  tile_t                     rd_tile;
  probe_t                    probe;

  // Walk and setup helpers.
  logic signed [COORD_W-1:0] px_c, py_c, base_h, base_v, ox, oy, cx, cy;
  logic signed [COORD_W-1:0] dlt, shifted, ratio_step;
  logic signed [DELTA_W-1:0] mul_a;
  logic signed [RATIO_W-1:0] mul_b, rs;
  logic                      walk_hit, walk_door, walk_end, walk_end_door;
  logic [MAG_W-1:0]          ax, ay;
  logic [DIST_W-1:0]         dist_sat;

  assign accept  = in_ch.valid && in_ch.ready;
  assign cast_go = accept && (in_ch.command == CMD_CAST);

  grw_tile_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (accept && (in_ch.command == CMD_WRITE)),
    .wr_addr ({in_ch.tile_row, in_ch.tile_col}),
    .wr_data (in_ch.tile_code),
    .rd_addr (probe.addr),
    .rd_data (rd_tile),
    .busy    (mem_busy)
  );

  grw_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .angle (in_ch.angle),
    .done  (cordic_done),
    .sin_q (sin_q),
    .cos_q (cos_q)
  );

  grw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  grw_sqrt u_sqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sqrt_start),
    .n     (sqx_r + sqy_r),
    .done  (sqrt_done),
    .root  (root)
  );

  // Geometry of the current walk. The horizontal walk probes one pixel above or below
  // the grid line, the vertical walk one pixel left or right of it.
  always_comb begin
    px_c   = $signed(COORD_W'(px_r));
    py_c   = $signed(COORD_W'(py_r));
    base_h = $signed(COORD_W'({py_r[PLAYER_W-1:TILE_SHIFT], TILE_SHIFT'(0)}))
             + (down_r ? TILE_RAW : '0);
    base_v = $signed(COORD_W'({px_r[PLAYER_W-1:TILE_SHIFT], TILE_SHIFT'(0)}))
             + (!left_r ? TILE_RAW : '0);
    if (!phase_r) begin
      ox    = '0;
      oy    = down_r ? PIXEL_RAW : -PIXEL_RAW;
      dlt   = base_h - py_c;
      mul_b = ct_r;
    end else begin
      ox    = left_r ? -PIXEL_RAW : PIXEL_RAW;
      oy    = '0;
      dlt   = base_v - px_c;
      mul_b = tn_r;
    end
    mul_a      = dlt[DELTA_W-1:0];
    shifted    = COORD_W'(prod_r >>> 16);
    rs         = mul_b >>> 2;
    ratio_step = rs[RATIO_W-1] ? COORD_W'(-rs) : COORD_W'(rs);
    // The probe at the current point on entry, at the next point while walking: the
    // read for the next step is issued while this step's tile is being checked.
    if (state_r == ST_PROBE) begin
      cx = wx_r + ox;
      cy = wy_r + oy;
    end else begin
      cx = wx_r + wsx_r + ox;
      cy = wy_r + wsy_r + oy;
    end
    probe         = probe_at(cx, cy, map_w_r, map_h_r);
    walk_door     = !stop_r && (rd_tile == TILE_DOOR);
    walk_hit      = stop_r || (rd_tile == TILE_WALL) || (rd_tile == TILE_DOOR);
    walk_end      = walk_hit || (k_r >= MAPREG_W'(MAP_SIDE));
    walk_end_door = walk_hit && walk_door;
    if (!phase_r) begin
      ax = cap_mag(hx_r - px_c);
      ay = cap_mag(hy_r - py_c);
    end else begin
      ax = cap_mag(vx_r - px_c);
      ay = cap_mag(vy_r - py_c);
    end
    dist_sat = (root > MAG_W'({DIST_W{1'b1}})) ? {DIST_W{1'b1}} : root[DIST_W-1:0];
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (cast_go) state_nxt = ST_TRIG;
      ST_TRIG:    if (cordic_done) state_nxt = ST_TAN;
      ST_TAN:     if (div_done) state_nxt = ST_COT;
      ST_COT:     if (div_done) state_nxt = ST_MUL;
      ST_MUL:     state_nxt = ST_LOAD;
      ST_LOAD:    state_nxt = ST_PROBE;
      ST_PROBE:   state_nxt = ST_WALK;
      ST_WALK: begin
        if (walk_end) state_nxt = phase_r ? ST_SQ_X : ST_MUL;
      end
      ST_SQ_X:    state_nxt = ST_SQ_Y;
      ST_SQ_Y:    state_nxt = ST_ROOT_GO;
      ST_ROOT_GO: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (sqrt_done) state_nxt = phase_r ? ST_EMIT : ST_SQ_X;
      end
      ST_EMIT:    if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_ch.ready  = (state_r == ST_IDLE) && !mem_busy;
    cfg_ch.ready = 1'b1;
    cordic_start = cast_go;
    div_start    = 1'b0;
    div_num      = sin_q;
    div_den      = cos_q;
    sqrt_start   = (state_r == ST_ROOT_GO);
    out_load     = 1'b0;
    case (state_r)
      ST_TRIG: div_start = cordic_done;
      ST_TAN: begin
        div_start = div_done;
        div_num   = cos_q;
        div_den   = sin_q;
      end
      ST_EMIT: out_load = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // Datapath next values.
  always_comb begin
    tn_nxt    = tn_r;
    ct_nxt    = ct_r;
    prod_nxt  = prod_r;
    wx_nxt    = wx_r;
    wy_nxt    = wy_r;
    wsx_nxt   = wsx_r;
    wsy_nxt   = wsy_r;
    k_nxt     = k_r;
    stop_nxt  = stop_r;
    phase_nxt = phase_r;
    hx_nxt    = hx_r;
    hy_nxt    = hy_r;
    vx_nxt    = vx_r;
    vy_nxt    = vy_r;
    hd_nxt    = hd_r;
    vd_nxt    = vd_r;
    sqx_nxt   = sqx_r;
    sqy_nxt   = sqy_r;
    hdist_nxt = hdist_r;
    case (state_r)
      ST_TAN: if (div_done) tn_nxt = div_quo;
      ST_COT: begin
        if (div_done) begin
          ct_nxt    = div_quo;
          phase_nxt = 1'b0;
        end
      end
      ST_MUL: prod_nxt = mul_a * mul_b;
      ST_LOAD: begin
        if (!phase_r) begin
          wy_nxt  = base_h;
          wx_nxt  = px_c + shifted;
          wsy_nxt = down_r ? TILE_RAW : -TILE_RAW;
          wsx_nxt = left_r ? -ratio_step : ratio_step;
        end else begin
          wx_nxt  = base_v;
          wy_nxt  = py_c + shifted;
          wsx_nxt = left_r ? -TILE_RAW : TILE_RAW;
          wsy_nxt = down_r ? ratio_step : -ratio_step;
        end
      end
      ST_PROBE: begin
        k_nxt    = '0;
        stop_nxt = probe.stop;
      end
      ST_WALK: begin
        if (walk_end) begin
          if (!phase_r) begin
            hx_nxt    = wx_r;
            hy_nxt    = wy_r;
            hd_nxt    = walk_end_door;
            phase_nxt = 1'b1;
          end else begin
            vx_nxt    = wx_r;
            vy_nxt    = wy_r;
            vd_nxt    = walk_end_door;
            phase_nxt = 1'b0;
          end
        end else begin
          wx_nxt   = wx_r + wsx_r;
          wy_nxt   = wy_r + wsy_r;
          k_nxt    = k_r + 1'b1;
          stop_nxt = probe.stop;
        end
      end
      ST_SQ_X: sqx_nxt = ax * ax;
      ST_SQ_Y: sqy_nxt = ay * ay;
      ST_ROOT: begin
        if (sqrt_done && !phase_r) begin
          hdist_nxt = dist_sat;
          phase_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      map_w_r     <= MAPREG_W'(MAP_SIDE);
      map_h_r     <= MAPREG_W'(MAP_SIDE);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_MAP_WIDTH) begin
          map_w_r <= cfg_ch.data;
        end else if (cfg_ch.index == REG_MAP_HEIGHT) begin
          map_h_r <= cfg_ch.data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cast_go) begin
      px_r   <= in_ch.player_x;
      py_r   <= in_ch.player_y;
      ang_r  <= in_ch.angle;
    end
    tn_r    <= tn_nxt;
    ct_r    <= ct_nxt;
    prod_r  <= prod_nxt;
    wx_r    <= wx_nxt;
    wy_r    <= wy_nxt;
    wsx_r   <= wsx_nxt;
    wsy_r   <= wsy_nxt;
    k_r     <= k_nxt;
    stop_r  <= stop_nxt;
    phase_r <= phase_nxt;
    hx_r    <= hx_nxt;
    hy_r    <= hy_nxt;
    vx_r    <= vx_nxt;
    vy_r    <= vy_nxt;
    hd_r    <= hd_nxt;
    vd_r    <= vd_nxt;
    sqx_r   <= sqx_nxt;
    sqy_r   <= sqy_nxt;
    hdist_r <= hdist_nxt;
    if (out_load) begin
      o_hx_r    <= sat_hit(hx_r);
      o_hy_r    <= sat_hit(hy_r);
      o_vx_r    <= sat_hit(vx_r);
      o_vy_r    <= sat_hit(vy_r);
      o_hdist_r <= hdist_r;
      o_vdist_r <= dist_sat;
      o_hd_r    <= hd_r;
      o_vd_r    <= vd_r;
    end
  end

  // Direction flags: facing down for angles in the open first half turn, facing left
  // strictly between a quarter and three quarters of a turn.
  always_comb begin
    down_r = (ang_r != '0) && !ang_r[ANGLE_W-1];
    left_r = (ang_r > ANGLE_W'(1 << (ANGLE_W-2))) && (ang_r < ANGLE_W'(3 << (ANGLE_W-2)));
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.h_hit_x    = o_hx_r;
  assign out_ch.h_hit_y    = o_hy_r;
  assign out_ch.v_hit_x    = o_vx_r;
  assign out_ch.v_hit_y    = o_vy_r;
  assign out_ch.h_distance = o_hdist_r;
  assign out_ch.v_distance = o_vdist_r;
  assign out_ch.h_door     = o_hd_r;
  assign out_ch.v_door     = o_vd_r;
endmodule
